[src/assert_macros.svh]
// Assertion macros shared by the box filter RTL.
// Defining NO_ASSERTIONS turns every use into nothing; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BB3_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BB3_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BB3_ASSERT(lbl, prop, msg)
`define BB3_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[src/bb3_pkg.sv]
// Types and constants for the 3x3 RGB box filter.
// No dependencies; used by bb3_mean and box_blur_3x3_rgb.
package bb3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int MIN_SIZE    = 3;
    localparam int RST_WIDTH   = 640;
    localparam int RST_HEIGHT  = 480;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int OROW_W      = $clog2(MAX_HEIGHT);
    localparam int ROW_W       = OROW_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic              is_padding;
    } t_in_beat;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_done;
    } t_out_beat;

    typedef struct packed {
        logic emit;
        logic border;
        logic done;
    } t_win_ctrl;

endpackage

[src/bb3_mean.sv]
// Sum and divide-by-nine stages of the box filter (border windows pass the centre pixel), with the output register.
// Depends on bb3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bb3_mean
    import bb3_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_win_valid,
    output logic            o_win_ready,
    input  t_pixel [8:0]    i_win,
    input  t_win_ctrl       i_ctrl,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_beat       o_out_beat
);

    logic                 r_v3;
    logic [SUM_W-1:0]     r_sum_r, r_sum_g, r_sum_b;
    logic                 r_border3;
    logic                 r_done3;
    logic                 r_v4;
    t_out_beat            r_out;

    logic                 en3, en4;
    logic [SUM_W-1:0]     n_sum_r, n_sum_g, n_sum_b;
    logic [SUM_W+RECIP_W-1:0] prod_r, prod_g, prod_b;

    function automatic logic [SUM_W-1:0] f_ext(input logic [CHAN_W-1:0] v);
        f_ext = {{(SUM_W-CHAN_W){1'b0}}, v};
    endfunction

    assign en4         = !r_v4 || i_out_ready;
    assign en3         = !r_v3 || en4;
    assign o_win_ready = en3;

    always_comb begin
        n_sum_r = ((f_ext(i_win[0].red) + f_ext(i_win[1].red))
                 + (f_ext(i_win[2].red) + f_ext(i_win[3].red)))
                + ((f_ext(i_win[4].red) + f_ext(i_win[5].red))
                 + (f_ext(i_win[6].red) + f_ext(i_win[7].red)))
                + f_ext(i_win[8].red);
        n_sum_g = ((f_ext(i_win[0].green) + f_ext(i_win[1].green))
                 + (f_ext(i_win[2].green) + f_ext(i_win[3].green)))
                + ((f_ext(i_win[4].green) + f_ext(i_win[5].green))
                 + (f_ext(i_win[6].green) + f_ext(i_win[7].green)))
                + f_ext(i_win[8].green);
        n_sum_b = ((f_ext(i_win[0].blue) + f_ext(i_win[1].blue))
                 + (f_ext(i_win[2].blue) + f_ext(i_win[3].blue)))
                + ((f_ext(i_win[4].blue) + f_ext(i_win[5].blue))
                 + (f_ext(i_win[6].blue) + f_ext(i_win[7].blue)))
                + f_ext(i_win[8].blue);
        if (i_ctrl.border) begin
            n_sum_r = f_ext(i_win[4].red);
            n_sum_g = f_ext(i_win[4].green);
            n_sum_b = f_ext(i_win[4].blue);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= i_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && i_win_valid) begin
            r_sum_r   <= n_sum_r;
            r_sum_g   <= n_sum_g;
            r_sum_b   <= n_sum_b;
            r_border3 <= i_ctrl.border;
            r_done3   <= i_ctrl.done;
        end
    end

    // The reciprocal 7282 / 2^16 gives the exact floor for every sum below 32768.
    assign prod_r = (SUM_W+RECIP_W)'(r_sum_r) * (SUM_W+RECIP_W)'(RECIP_NINE);
    assign prod_g = (SUM_W+RECIP_W)'(r_sum_g) * (SUM_W+RECIP_W)'(RECIP_NINE);
    assign prod_b = (SUM_W+RECIP_W)'(r_sum_b) * (SUM_W+RECIP_W)'(RECIP_NINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            if (r_border3) begin
                r_out.out_red   <= r_sum_r[CHAN_W-1:0];
                r_out.out_green <= r_sum_g[CHAN_W-1:0];
                r_out.out_blue  <= r_sum_b[CHAN_W-1:0];
            end else begin
                r_out.out_red   <= prod_r[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
                r_out.out_green <= prod_g[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
                r_out.out_blue  <= prod_b[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
            end
            r_out.frame_done <= r_done3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_beat  = r_out;

    `BB3_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid && o_win_ready, "pipeline not empty after reset")
    `BB3_ASSERT(a_sum_hold, r_v3 && !en4 |=> r_v3 && $stable(r_sum_r) && $stable(r_sum_b), "sum stage lost a held beat")
    `BB3_ASSERT(a_interior_range, r_v3 && !r_border3 |-> r_sum_g <= SUM_W'(9 * 255), "window sum out of range")

endmodule

[src/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box filter: counters, line stores and window.
// Depends on bb3_pkg, bb3_mean and assert_macros.svh.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_ready | o_out_beat (t_out_beat)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One input beat is taken per clock unless the pipeline stalls; each line store is
// read once and written once per beat. A result passes the stage 1, window, sum and
// output registers after the beat that completes its window, so the stream runs one
// row plus one pixel late. Reset clears counters and pipeline valids and sets the frame
// to 640 by 480; the line stores need no clearing pass. A stalled output holds the
// pipeline, and input is taken again as soon as the first stage can move.
`include "assert_macros.svh"

module box_blur_3x3_rgb
    import bb3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COL_W-1:0]  r_wm1;
    logic [OROW_W-1:0] r_hm1;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_ocol;
    logic [OROW_W-1:0] r_orow;

    t_pixel            r_up_mem  [MAX_WIDTH];
    t_pixel            r_mid_mem [MAX_WIDTH];
    t_pixel            r_up_q, r_mid_q;

    logic              r_v1;
    t_pixel            r_s1_pix;
    logic [COL_W-1:0]  r_s1_col;
    t_win_ctrl         r_s1_ctrl;

    logic              r_v2;
    t_pixel [8:0]      r_win;
    t_win_ctrl         r_s2_ctrl;

    logic              cfg_wr, cfg_restart;
    logic              in_acc, flushing, ignored, take, mv12, en2, win_ready;
    t_pixel            pix;
    t_win_ctrl         n_ctrl;
    logic [COL_W-1:0]  n_wm1;
    logic [OROW_W-1:0] n_hm1;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign cfg_restart = cfg_wr && (i_cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});

    always_comb begin
        if (32'(i_cfg_data) < 32'(MIN_SIZE)) begin
            n_wm1 = COL_W'(MIN_SIZE - 1);
            n_hm1 = OROW_W'(MIN_SIZE - 1);
        end else begin
            n_wm1 = (32'(i_cfg_data) > 32'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH - 1)
                                                       : COL_W'(i_cfg_data - 1'b1);
            n_hm1 = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? OROW_W'(MAX_HEIGHT - 1)
                                                        : OROW_W'(i_cfg_data - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= COL_W'(RST_WIDTH - 1);
            r_hm1 <= OROW_W'(RST_HEIGHT - 1);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_wm1 <= n_wm1;
                CFG_FRAME_HEIGHT: r_hm1 <= n_hm1;
                default: ;
            endcase
        end
    end

    assign en2        = !r_v2 || win_ready;
    assign mv12       = r_v1 && en2;
    assign o_in_ready = !r_v1 || en2;
    assign in_acc     = i_in_valid && o_in_ready;
    assign flushing   = r_row > {1'b0, r_hm1};
    assign ignored    = i_in_beat.is_padding && !flushing;
    assign take       = in_acc && !ignored && !cfg_wr;

    always_comb begin
        pix = '0;
        if (!flushing) begin
            pix.red   = i_in_beat.in_red;
            pix.green = i_in_beat.in_green;
            pix.blue  = i_in_beat.in_blue;
        end
        n_ctrl.emit   = !(r_row == '0 || (r_row == ROW_W'(1) && r_col == '0));
        n_ctrl.border = r_orow == '0 || r_orow == r_hm1 || r_ocol == '0 || r_ocol == r_wm1;
        n_ctrl.done   = n_ctrl.emit && r_orow == r_hm1 && r_ocol == r_wm1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else if (take) begin
            if (n_ctrl.done) begin
                r_col  <= '0;
                r_row  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                if (r_col == r_wm1) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                if (n_ctrl.emit) begin
                    if (r_ocol == r_wm1) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + 1'b1;
                    end else begin
                        r_ocol <= r_ocol + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_up_q            <= r_up_mem[r_col];
            r_mid_q           <= r_mid_mem[r_col];
            r_mid_mem[r_col]  <= pix;
        end
        if (mv12) begin
            r_up_mem[r_s1_col] <= r_mid_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (take) begin
            r_v1 <= 1'b1;
        end else if (en2) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_pix  <= pix;
            r_s1_col  <= r_col;
            r_s1_ctrl <= n_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1 && r_s1_ctrl.emit;
        end
    end

    // Window rows run top to bottom, columns oldest to newest.
    always_ff @(posedge i_clk) begin
        if (mv12) begin
            r_win[0]  <= r_win[1];
            r_win[1]  <= r_win[2];
            r_win[2]  <= r_up_q;
            r_win[3]  <= r_win[4];
            r_win[4]  <= r_win[5];
            r_win[5]  <= r_mid_q;
            r_win[6]  <= r_win[7];
            r_win[7]  <= r_win[8];
            r_win[8]  <= r_s1_pix;
            r_s2_ctrl <= r_s1_ctrl;
        end
    end

    bb3_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win_valid (r_v2),
        .o_win_ready (win_ready),
        .i_win       (r_win),
        .i_ctrl      (r_s2_ctrl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    `BB3_ASSERT(a_col_range, r_col <= r_wm1 && r_ocol <= r_wm1, "column counter past row end")
    `BB3_ASSERT(a_row_range, r_row <= ({1'b0, r_hm1} + ROW_W'(2)), "row counter past flush")
    `BB3_ASSERT(a_done_restarts, take && n_ctrl.done |=> r_row == '0 && r_orow == '0, "frame end did not restart counters")

endmodule

[test/box_blur_3x3_rgb_tb.sv]
// Self-checking testbench for box_blur_3x3_rgb: random pixel frames of many sizes,
// predicted in step with the input beats and compared with every output beat.
// Depends on bb3_pkg and the box_blur_3x3_rgb RTL.
`timescale 1ns / 100ps

module box_blur_3x3_rgb_tb;
    import bb3_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int QUIET_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int WINDOW_TAPS  = 9;
    localparam int unsigned ALL_PIXELS = 32'hFFFF_FFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef enum int {PIX_RANDOM, PIX_EXTREME, PIX_WHITE, PIX_BLACK} t_pix_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_in_beat    pixels_to_send [$];
    t_out_beat   awaited_pixels [$];
    int unsigned items_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          need_restart = 1'b0;

    // Shadow of the filter state.
    logic [CFG_DATA_W-1:0] cfg_width = CFG_DATA_W'(RST_WIDTH);
    logic [CFG_DATA_W-1:0] cfg_height = CFG_DATA_W'(RST_HEIGHT);
    t_pixel      upper_store [MAX_WIDTH] = '{default: '0};
    t_pixel      middle_store [MAX_WIDTH] = '{default: '0};
    t_pixel      win [WINDOW_TAPS] = '{default: '0};
    int unsigned in_col = 0;
    int unsigned in_row = 0;
    int unsigned out_count = 0;

    box_blur_3x3_rgb dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] v,
                                               input int unsigned hi);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_count = 0;
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH: begin
                cfg_width = data;
                restart_frame();
            end
            CFG_FRAME_HEIGHT: begin
                cfg_height = data;
                restart_frame();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_blur(input t_in_beat beat);
        int unsigned w, h, col, pos, k, r, c, i;
        int unsigned sum_r, sum_g, sum_b;
        bit flushing;
        t_pixel px;
        t_out_beat res;
        w = clamp_size(cfg_width, MAX_WIDTH);
        h = clamp_size(cfg_height, MAX_HEIGHT);
        flushing = (in_row >= h);
        // Padding within the frame leaves everything untouched.
        if (!(beat.is_padding && !flushing)) begin
            px = '0;
            if (!flushing) begin
                px.red   = beat.in_red;
                px.green = beat.in_green;
                px.blue  = beat.in_blue;
            end
            col = (in_col >= w) ? w - 1 : in_col;
            pos = in_row * w + col;
            for (i = 0; i < 3; i++) begin
                win[i * 3]     = win[i * 3 + 1];
                win[i * 3 + 1] = win[i * 3 + 2];
            end
            win[2] = upper_store[col];
            win[5] = middle_store[col];
            win[8] = px;
            upper_store[col]  = middle_store[col];
            middle_store[col] = px;
            in_col = col + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (pos >= w + 1) begin
                k = out_count;
                r = k / w;
                c = k % w;
                if (r >= 1 && r + 2 <= h && c >= 1 && c + 2 <= w) begin
                    sum_r = 0;
                    sum_g = 0;
                    sum_b = 0;
                    for (i = 0; i < WINDOW_TAPS; i++) begin
                        sum_r += win[i].red;
                        sum_g += win[i].green;
                        sum_b += win[i].blue;
                    end
                    res.out_red   = CHAN_W'(sum_r / WINDOW_TAPS);
                    res.out_green = CHAN_W'(sum_g / WINDOW_TAPS);
                    res.out_blue  = CHAN_W'(sum_b / WINDOW_TAPS);
                end else begin
                    res.out_red   = win[4].red;
                    res.out_green = win[4].green;
                    res.out_blue  = win[4].blue;
                end
                res.frame_done = (k + 1 >= w * h);
                if (res.frame_done) restart_frame();
                else out_count = k + 1;
                awaited_pixels.push_back(res);
            end
        end
    endfunction

    function automatic t_in_beat draw_pixel(input t_pix_style style, input bit pad);
        t_in_beat b;
        b.in_red   = CHAN_W'($urandom);
        b.in_green = CHAN_W'($urandom);
        b.in_blue  = CHAN_W'($urandom);
        case (style)
            PIX_EXTREME: begin
                b.in_red   = $urandom_range(1) ? 8'hFF : 8'h00;
                b.in_green = $urandom_range(1) ? 8'hFF : 8'h00;
                b.in_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            PIX_WHITE: begin
                b.in_red   = '1;
                b.in_green = '1;
                b.in_blue  = '1;
            end
            PIX_BLACK: begin
                b.in_red   = '0;
                b.in_green = '0;
                b.in_blue  = '0;
            end
            default: begin
            end
        endcase
        b.is_padding = pad;
        return b;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size(input int unsigned hi);
        if ($urandom_range(7) == 0) return CFG_DATA_W'($urandom_range(MIN_SIZE - 1));
        return CFG_DATA_W'($urandom_range(MIN_SIZE, hi));
    endfunction

    // Queues pixels first..last-1 of a frame at the current size, with random padding
    // beats, and the flush beats as well when the frame is completed.
    task automatic feed_frame(input int unsigned first, input int unsigned last,
                              input int unsigned noise_pct, input t_pix_style style);
        int unsigned w, total, n;
        w = clamp_size(cfg_width, MAX_WIDTH);
        total = w * clamp_size(cfg_height, MAX_HEIGHT);
        for (n = first; n < last && n < total; n++) begin
            if ($urandom_range(99) < noise_pct)
                pixels_to_send.push_back(draw_pixel(style, 1'b1));
            pixels_to_send.push_back(draw_pixel(style, 1'b0));
            items_queued++;
        end
        if (last >= total) begin
            for (n = 0; n <= w; n++) begin
                pixels_to_send.push_back(draw_pixel(PIX_RANDOM, $urandom_range(99) >= noise_pct));
                items_queued++;
            end
        end
    endtask

    task automatic settle();
        while (pixels_to_send.size() != 0 || i_in_valid || awaited_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_config(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_frame();
        int unsigned total, cut;
        t_pix_style style;
        style = ($urandom_range(9) < 7) ? PIX_RANDOM : t_pix_style'($urandom_range(3));
        if (need_restart || $urandom_range(1)) begin
            write_register(CFG_FRAME_WIDTH, pick_size(10));
            write_register(CFG_FRAME_HEIGHT, pick_size(6));
            need_restart = 1'b0;
        end
        total = clamp_size(cfg_width, MAX_WIDTH) * clamp_size(cfg_height, MAX_HEIGHT);
        cut = $urandom_range(1, total - 1);
        case ($urandom_range(9))
            0: begin
                feed_frame(0, cut, 10, style);
                need_restart = 1'b1;
            end
            1: begin
                feed_frame(0, cut, 10, style);
                write_register($urandom_range(1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                               CFG_DATA_W'($urandom));
                feed_frame(cut, ALL_PIXELS, 10, style);
            end
            default: feed_frame(0, ALL_PIXELS, 10, style);
        endcase
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) predict_blur(i_in_beat);
            if (!i_in_valid || o_in_ready) begin
                if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_beat  <= pixels_to_send.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : output_check
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected output beat %0d %0d %0d done %0b", $time,
                             o_out_beat.out_red, o_out_beat.out_green,
                             o_out_beat.out_blue, o_out_beat.frame_done);
            end else begin
                want = awaited_pixels.pop_front();
                check_field("red", want.out_red, o_out_beat.out_red);
                check_field("green", want.out_green, o_out_beat.out_green);
                check_field("blue", want.out_blue, o_out_beat.out_blue);
                check_field("frame_done", CHAN_W'(want.frame_done),
                            CHAN_W'(o_out_beat.frame_done));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned target;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 30;
        recv_idle_pct = 48;
        // Smallest frame: padding ahead of and inside the frame, then a dark frame straight
        // after, flushed partly by pixel beats, and then a frame of extreme values.
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_SIZE));
        write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_SIZE));
        pixels_to_send.push_back(draw_pixel(PIX_WHITE, 1'b1));
        feed_frame(0, 4, 0, PIX_WHITE);
        pixels_to_send.push_back(draw_pixel(PIX_BLACK, 1'b1));
        feed_frame(4, ALL_PIXELS, 0, PIX_WHITE);
        feed_frame(0, ALL_PIXELS, 50, PIX_BLACK);
        feed_frame(0, ALL_PIXELS, 0, PIX_EXTREME);

        // Out-of-range sizes are clamped; the wide and tall frames are cut short.
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        write_register(CFG_FRAME_HEIGHT, '0);
        feed_frame(0, 40, 2, PIX_RANDOM);
        write_register(CFG_FRAME_WIDTH, '1);
        write_register(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_SIZE));
        feed_frame(0, 40, 2, PIX_RANDOM);
        write_register(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_SIZE - 1));
        write_register(CFG_FRAME_HEIGHT, '1);
        feed_frame(0, 60, 2, PIX_RANDOM);
        need_restart = 1'b1;

        send_idle_pct = 48;
        recv_idle_pct = 30;
        target = items_queued + 230;
        while (items_queued < target) random_frame();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        target = items_queued + 230;
        while (items_queued < target) random_frame();

        settle();
        if (mismatch_count == 0 && awaited_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
